// ===== rtl/mlfq_pkg.sv =====
// ----------------------------------------------------------------------------
// mlfq_pkg
// Types and constants shared by the multilevel feedback queue scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  localparam int unsigned LEVELS      = 3;
  localparam int unsigned LEVEL_DEPTH = 16;
  localparam int unsigned SLOTS       = LEVELS * LEVEL_DEPTH;

  localparam int unsigned LVL_W   = $clog2(LEVELS);
  localparam int unsigned PTR_W   = $clog2(LEVEL_DEPTH);
  localparam int unsigned CNT_W   = $clog2(LEVEL_DEPTH + 1);
  localparam int unsigned ADDR_W  = $clog2(SLOTS);
  localparam int unsigned TOTAL_W = $clog2(SLOTS + 1);

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 16;

  localparam logic [15:0] QUANTUM_RESET = 16'd4;
  localparam logic [15:0] BOOST_RESET   = 16'd8;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_QUANTUM = 1'b0,
    CFG_BOOST_PERIOD = 1'b1
  } cfg_idx_e;

  // operation codes
  typedef enum logic {
    OP_ADD      = 1'b0,
    OP_DISPATCH = 1'b1
  } op_e;

  typedef struct packed {
    logic        op;
    logic [7:0]  new_id;
    logic [15:0] new_burst;
    logic [31:0] new_arrival;
  } mlfq_in_t;

  typedef struct packed {
    logic        add_rejected;
    logic        idle;
    logic        boosted;
    logic [7:0]  run_id;
    logic [1:0]  run_level;
    logic [15:0] run_time;
    logic        finished;
    logic [31:0] first_start;
    logic [31:0] stop_time;
    logic [31:0] turnaround;
  } mlfq_out_t;

  // one stored job slot
  typedef struct packed {
    logic        started;
    logic [31:0] start;
    logic [31:0] arrival;
    logic [7:0]  id;
    logic [15:0] burst;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_CHECK,
    ST_MOD,
    ST_BOOST_RD,
    ST_BOOST_WR,
    ST_BOOST_END,
    ST_POP,
    ST_EXEC,
    ST_PUSH,
    ST_RESP
  } state_e;

endpackage

// ===== rtl/mlfq_ram.sv =====
// ----------------------------------------------------------------------------
// mlfq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mlfq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/mlfq_rem.sv =====
// ----------------------------------------------------------------------------
// mlfq_rem
// Bit-serial remainder unit: 32-bit dividend modulo 16-bit divisor,
// one restoring shift-subtract step per cycle.
// ----------------------------------------------------------------------------
module mlfq_rem (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [15:0] rem_o
);

  logic [31:0] div_q, div_d;
  logic [15:0] dsr_q, dsr_d;
  logic [16:0] r_q, r_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [16:0] r_sh;

  // operand load on start, else one shift-subtract step
  always_comb begin
    r_sh   = {r_q[15:0], div_q[31]};
    div_d  = div_q;
    dsr_d  = dsr_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      div_d = dividend_i;
      dsr_d = divisor_i;
      r_d   = '0;
      cnt_d = 6'd32;
    end else if (cnt_q != '0) begin
      div_d = {div_q[30:0], 1'b0};
      r_d   = (r_sh >= {1'b0, dsr_q}) ? r_sh - {1'b0, dsr_q} : r_sh;
      cnt_d = cnt_q - 6'd1;
      done_d = (cnt_q == 6'd1);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    dsr_q <= dsr_d;
    r_q   <= r_d;
  end

  assign done_o = done_q;
  assign rem_o  = r_q[15:0];

endmodule

// ===== rtl/multilevel_feedback_queue_scheduler.sv =====
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler
// Multilevel feedback queue scheduler with priority boost.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start_i is high and busy_o is low; req_i
//   carries op, id, burst and arrival. Every transaction gives exactly one
//   result on res_o, marked by done_o for one cycle; the receiver cannot
//   stall, so the result must be taken in that cycle.
//   Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//   (0 time quantum, 1 boost period); write only while busy_o is low, which the block itself does not enforce.
//   Sequence: an add passes ST_ADD; a dispatch passes ST_CHECK, which gives
//   the idle result when nothing is stored, then ST_MOD for the serial
//   remainder (time mod boost period) when time and period are nonzero, a
//   boost walk (ST_BOOST_RD and ST_BOOST_WR for every stored job, then
//   ST_BOOST_END) when the remainder is zero, and ST_POP, ST_EXEC, ST_PUSH
//   and ST_RESP. One transaction is handled at a time.
//   Reset clears time, queue pointers and counts; the job memories need no
//   clearing since a slot is read only after it was written.
// ----------------------------------------------------------------------------
module multilevel_feedback_queue_scheduler (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  mlfq_pkg::mlfq_in_t                 req_i,
  output logic                               busy_o,
  output logic                               done_o,
  output mlfq_pkg::mlfq_out_t                res_o,
  input  logic                               cfg_we_i,
  input  logic [mlfq_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mlfq_pkg::CFG_W-1:0]         cfg_wdata_i
);

  import mlfq_pkg::*;

  state_e            state_q, state_d;
  logic [15:0]       tq_q, bp_q;
  logic [31:0]       now_q, now_d;
  logic [PTR_W-1:0]  head_q [LEVELS];
  logic [PTR_W-1:0]  head_d [LEVELS];
  logic [PTR_W-1:0]  tail_q [LEVELS];
  logic [PTR_W-1:0]  tail_d [LEVELS];
  logic [CNT_W-1:0]  cnt_q  [LEVELS];
  logic [CNT_W-1:0]  cnt_d  [LEVELS];
  logic              bank_q, bank_d;
  logic [TOTAL_W-1:0] idx_q, idx_d;
  mlfq_in_t          req_q;
  logic              boosted_q, boosted_d;
  logic [LVL_W-1:0]  found_q, found_d;
  job_t              job_q, job_d;
  logic [15:0]       run_q, run_d;
  mlfq_out_t         res_q, res_d;
  logic              done_q, done_d;

  // memory ports
  logic              we;
  logic              we_bank;
  logic [ADDR_W-1:0] waddr, raddr;
  job_t              wdata;
  logic [$bits(job_t)-1:0] rd0, rd1;
  job_t              rdata;

  // remainder unit
  logic              rem_start;
  logic              rem_done;
  logic [15:0]       rem;

  // level search helpers
  logic              any_job;
  logic [LVL_W-1:0]  low_lv;
  logic [LVL_W-1:0]  tgt;
  logic [15:0]       burst_left;
  int unsigned       base, fill;

  function automatic logic [ADDR_W-1:0] slot_addr(logic [LVL_W-1:0] lv,
                                                  logic [PTR_W-1:0] ptr);
    slot_addr = ADDR_W'(lv) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(ptr);
  endfunction

  function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
    next_ptr = (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // job memory banks, swapped after each boost
  mlfq_ram #(.WIDTH($bits(job_t)), .DEPTH(SLOTS)) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (we && !we_bank),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd0)
  );

  mlfq_ram #(.WIDTH($bits(job_t)), .DEPTH(SLOTS)) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (we && we_bank),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd1)
  );

  assign rdata = bank_q ? job_t'(rd1) : job_t'(rd0);

  mlfq_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (now_q),
    .divisor_i  (bp_q),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  // highest non-empty level
  always_comb begin
    any_job = 1'b0;
    low_lv  = '0;
    for (int lv = LEVELS - 1; lv >= 0; lv--) begin
      if (cnt_q[lv] != '0) begin
        any_job = 1'b1;
        low_lv  = LVL_W'(lv);
      end
    end
  end

  // sequencer: next state, queue pointers and memory control
  always_comb begin
    state_d   = state_q;
    now_d     = now_q;
    head_d    = head_q;
    tail_d    = tail_q;
    cnt_d     = cnt_q;
    bank_d    = bank_q;
    idx_d     = idx_q;
    boosted_d = boosted_q;
    found_d   = found_q;
    job_d     = job_q;
    run_d     = run_q;
    res_d     = res_q;
    done_d    = 1'b0;
    we        = 1'b0;
    we_bank   = bank_q;
    waddr     = '0;
    wdata     = job_q;
    raddr     = '0;
    rem_start = 1'b0;
    tgt       = found_q;
    burst_left = job_q.burst - run_q;
    base      = 0;
    fill      = 0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          boosted_d = 1'b0;
          state_d   = (req_i.op == OP_ADD) ? ST_ADD : ST_CHECK;
        end
      end

      // add transaction: push at tail of the top level, or reject when it is full
      ST_ADD: begin
        res_d = '0;
        if (cnt_q[0] == CNT_W'(LEVEL_DEPTH)) begin
          res_d.add_rejected = 1'b1;
        end else begin
          we            = 1'b1;
          waddr         = slot_addr('0, tail_q[0]);
          wdata.started = 1'b0;
          wdata.start   = '0;
          wdata.arrival = req_q.new_arrival;
          wdata.id      = req_q.new_id;
          wdata.burst   = req_q.new_burst;
          tail_d[0]     = next_ptr(tail_q[0]);
          cnt_d[0]      = cnt_q[0] + CNT_W'(1);
        end
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end

      // dispatch: empty check and boost test
      ST_CHECK: begin
        if (!any_job) begin
          res_d      = '0;
          res_d.idle = 1'b1;
          done_d     = 1'b1;
          state_d    = ST_IDLE;
        end else if (bp_q != '0 && now_q != '0) begin
          rem_start = 1'b1;
          state_d   = ST_MOD;
        end else begin
          state_d = ST_POP;
        end
      end

      ST_MOD: begin
        if (rem_done) begin
          if (rem == '0) begin
            boosted_d = 1'b1;
            idx_d     = '0;
            state_d   = ST_BOOST_RD;
          end else begin
            state_d = ST_POP;
          end
        end
      end

      // boost walk: pop in level then fifo order
      ST_BOOST_RD: begin
        if (any_job) begin
          raddr          = slot_addr(low_lv, head_q[low_lv]);
          head_d[low_lv] = next_ptr(head_q[low_lv]);
          cnt_d[low_lv]  = cnt_q[low_lv] - CNT_W'(1);
          state_d        = ST_BOOST_WR;
        end else begin
          state_d = ST_BOOST_END;
        end
      end

      // refill the other bank in order, spilling level by level
      ST_BOOST_WR: begin
        we      = 1'b1;
        we_bank = !bank_q;
        waddr   = ADDR_W'(idx_q);
        wdata   = rdata;
        idx_d   = idx_q + TOTAL_W'(1);
        state_d = ST_BOOST_RD;
      end

      ST_BOOST_END: begin
        for (int lv = 0; lv < LEVELS; lv++) begin
          base = lv * LEVEL_DEPTH;
          if (int'(idx_q) >= base + LEVEL_DEPTH) begin
            fill = LEVEL_DEPTH;
          end else if (int'(idx_q) > base) begin
            fill = int'(idx_q) - base;
          end else begin
            fill = 0;
          end
          head_d[lv] = '0;
          cnt_d[lv]  = CNT_W'(fill);
          tail_d[lv] = (fill == LEVEL_DEPTH) ? '0 : PTR_W'(fill);
        end
        bank_d  = !bank_q;
        state_d = ST_POP;
      end

      // pop the head of the highest non-empty level
      ST_POP: begin
        found_d        = low_lv;
        raddr          = slot_addr(low_lv, head_q[low_lv]);
        head_d[low_lv] = next_ptr(head_q[low_lv]);
        cnt_d[low_lv]  = cnt_q[low_lv] - CNT_W'(1);
        state_d        = ST_EXEC;
      end

      // run length and start stamp
      ST_EXEC: begin
        job_d = rdata;
        if (!rdata.started) begin
          job_d.started = 1'b1;
          job_d.start   = now_q;
        end
        run_d   = (tq_q < rdata.burst) ? tq_q : rdata.burst;
        state_d = ST_PUSH;
      end

      // advance time, demote or requeue
      ST_PUSH: begin
        now_d = now_q + 32'(run_q);
        if (burst_left != '0) begin
          tgt = (int'(found_q) + 1 < LEVELS) ? found_q + LVL_W'(1) : found_q;
          if (cnt_q[tgt] == CNT_W'(LEVEL_DEPTH)) begin
            tgt = found_q;
          end
          we          = 1'b1;
          waddr       = slot_addr(tgt, tail_q[tgt]);
          wdata       = job_q;
          wdata.burst = burst_left;
          tail_d[tgt] = next_ptr(tail_q[tgt]);
          cnt_d[tgt]  = cnt_q[tgt] + CNT_W'(1);
        end
        state_d = ST_RESP;
      end

      ST_RESP: begin
        res_d             = '0;
        res_d.boosted     = boosted_q;
        res_d.run_id      = job_q.id;
        res_d.run_level   = 2'(found_q);
        res_d.run_time    = run_q;
        res_d.first_start = job_q.start;
        res_d.stop_time   = now_q;
        if (burst_left == '0) begin
          res_d.finished   = 1'b1;
          res_d.turnaround = now_q - job_q.arrival;
        end
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      now_q     <= '0;
      bank_q    <= 1'b0;
      done_q    <= 1'b0;
      boosted_q <= 1'b0;
      for (int lv = 0; lv < LEVELS; lv++) begin
        head_q[lv] <= '0;
        tail_q[lv] <= '0;
        cnt_q[lv]  <= '0;
      end
    end else begin
      state_q   <= state_d;
      now_q     <= now_d;
      bank_q    <= bank_d;
      done_q    <= done_d;
      boosted_q <= boosted_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      cnt_q     <= cnt_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tq_q <= QUANTUM_RESET;
      bp_q <= BOOST_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TIME_QUANTUM: tq_q <= cfg_wdata_i;
        CFG_BOOST_PERIOD: bp_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      req_q <= req_i;
    end
    idx_q   <= idx_d;
    found_q <= found_d;
    job_q   <= job_d;
    run_q   <= run_d;
    res_q   <= res_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  // a transaction always ends with a result strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("busy dropped without result");

  // neither the top nor the bottom level ever holds more than its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[0] <= CNT_W'(LEVEL_DEPTH)) && (cnt_q[LEVELS-1] <= CNT_W'(LEVEL_DEPTH)))
    else $error("level count overflow");

  // banks swap only at the end of a boost
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bank_q != $past(bank_q)) |-> ($past(state_q) == ST_BOOST_END))
    else $error("unexpected bank swap");

  // an idle dispatch never reports a boost or a finish
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.idle) |-> (!res_o.boosted && !res_o.finished))
    else $error("idle result with run fields");

  // the remainder unit only reports while waiting for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_done |-> (state_q == ST_MOD))
    else $error("stray remainder completion");

endmodule
